// ----- sv/saic_pkg.sv -----
// Shared types and codes for the actuator safety interlock controller.
// Depends on nothing; imported by saic_eval and the top level.
package saic_pkg;

    // Request types
    localparam logic [2:0] REQ_TICK  = 3'd0;
    localparam logic [2:0] REQ_SET   = 3'd1;
    localparam logic [2:0] REQ_EMERG = 3'd2;
    localparam logic [2:0] REQ_WARN  = 3'd3;
    localparam logic [2:0] REQ_STOP  = 3'd4;

    // Actuator codes, also the bit positions in every on mask
    localparam logic [2:0] ACT_HEATER1 = 3'd0;
    localparam logic [2:0] ACT_HEATER2 = 3'd1;
    localparam logic [2:0] ACT_EXHAUST = 3'd2;
    localparam logic [2:0] ACT_CIRC    = 3'd3;
    localparam logic [2:0] ACT_PUMP    = 3'd4;
    localparam logic [2:0] ACT_LIGHT   = 3'd5;

    localparam logic [5:0] M_H1 = 6'b000001;
    localparam logic [5:0] M_H2 = 6'b000010;
    localparam logic [5:0] M_EX = 6'b000100;
    localparam logic [5:0] M_CI = 6'b001000;
    localparam logic [5:0] M_PU = 6'b010000;
    localparam logic [5:0] M_LI = 6'b100000;

    // Bits of forced_off that a runtime limit can never set
    localparam logic [4:0] FORCED_NEVER = 5'b01100;

    // Toggle time slots
    localparam logic [1:0] TG_H1 = 2'd0;
    localparam logic [1:0] TG_H2 = 2'd1;
    localparam logic [1:0] TG_EX = 2'd2;
    localparam logic [1:0] TG_PU = 2'd3;

    // Run time slots
    localparam logic [1:0] RN_H1 = 2'd0;
    localparam logic [1:0] RN_H2 = 2'd1;
    localparam logic [1:0] RN_PU = 2'd2;

    // Block reasons
    localparam logic [1:0] RSN_NONE        = 2'd0;
    localparam logic [1:0] RSN_EXH_BLOCKED = 2'd1;
    localparam logic [1:0] RSN_HTR_BLOCKED = 2'd2;
    localparam logic [1:0] RSN_CYCLE       = 2'd3;

    // Emergency kinds
    localparam logic [2:0] EMG_LOW_TEMP  = 3'd0;
    localparam logic [2:0] EMG_HIGH_TEMP = 3'd1;
    localparam logic [2:0] EMG_FROST     = 3'd2;
    localparam logic [2:0] EMG_SECURITY  = 3'd3;
    localparam logic [2:0] EMG_LEAK      = 3'd4;
    localparam logic [2:0] EMG_POWER     = 3'd5;
    localparam logic [2:0] EMG_HIGH_CO2  = 3'd6;

    // Warning kinds
    localparam logic [2:0] WRN_TEMP_LOW  = 3'd0;
    localparam logic [2:0] WRN_TEMP_HIGH = 3'd1;
    localparam logic [2:0] WRN_HUM_HIGH  = 3'd3;
    localparam logic [2:0] WRN_CO2_LOW   = 3'd4;
    localparam logic [2:0] WRN_CO2_HIGH  = 3'd5;

    // Alarm tones
    localparam logic [1:0] TONE_NONE  = 2'd0;
    localparam logic [1:0] TONE_BEEP  = 2'd1;
    localparam logic [1:0] TONE_BURST = 2'd2;

    // Configuration register indexes and reset values
    localparam logic [2:0] CFG_HTR_MIN   = 3'd0;
    localparam logic [2:0] CFG_EXH_MIN   = 3'd1;
    localparam logic [2:0] CFG_PUMP_MIN  = 3'd2;
    localparam logic [2:0] CFG_HTR_MAX   = 3'd3;
    localparam logic [2:0] CFG_PUMP_MAX  = 3'd4;
    localparam logic [2:0] CFG_POLARITY  = 3'd5;

    localparam logic [31:0] RST_HTR_MIN  = 32'd60000;
    localparam logic [31:0] RST_EXH_MIN  = 32'd30000;
    localparam logic [31:0] RST_PUMP_MIN = 32'd60000;
    localparam logic [31:0] RST_HTR_MAX  = 32'd3600000;
    localparam logic [31:0] RST_PUMP_MAX = 32'd600000;

    typedef struct packed {
        logic [31:0] heater_min_cycle_ms;
        logic [31:0] exhaust_min_cycle_ms;
        logic [31:0] pump_min_cycle_ms;
        logic [31:0] heater_max_runtime_ms;
        logic [31:0] pump_max_runtime_ms;
        logic        relay_polarity_low;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [2:0]  actuator;
        logic        turn_on;
        logic [2:0]  event_code;
        logic [31:0] now_ms;
    } item_t;

    typedef struct packed {
        logic [5:0] on_flags;
        logic       emergency_mode;
        logic [2:0] last_emergency;
        logic       interlock_seen;
    } ctl_t;

    typedef struct packed {
        logic       accepted;
        logic [1:0] block_reason;
        logic [5:0] actuator_on;
        logic [5:0] relay_levels;
        logic       any_on;
        logic [4:0] forced_off;
        logic       emergency_active;
        logic [2:0] emergency_kind;
        logic       interlock_flag;
        logic [1:0] alarm_tone;
    } res_t;

endpackage

// ----- sv/saic_eval.sv -----
// Next-state and result logic for one request of the interlock controller.
// Depends on saic_pkg; instantiated by the top level.
module saic_eval #(
    parameter int TIME_BITS = 32
) (
    input  saic_pkg::cfg_t                  cfg,
    input  saic_pkg::item_t                 item,
    input  saic_pkg::ctl_t                  ctl_cur,
    input  logic [3:0][TIME_BITS-1:0]       tog_cur,
    input  logic [2:0][TIME_BITS-1:0]       run_cur,
    output saic_pkg::ctl_t                  ctl_next,
    output logic [3:0][TIME_BITS-1:0]       tog_next,
    output logic [2:0][TIME_BITS-1:0]       run_next,
    output saic_pkg::res_t                  res
);
    import saic_pkg::*;

    logic [63:0]          now_wide;
    logic [TIME_BITS-1:0] now_t;

    // Wrapping time since a stamp is shorter than a limit
    function automatic logic too_soon(input logic [TIME_BITS-1:0] now,
                                      input logic [TIME_BITS-1:0] stamp,
                                      input logic [31:0] limit);
        logic [TIME_BITS-1:0] dt;
        dt = now - stamp;
        return 64'(dt) < 64'(limit);
    endfunction

    // Relay with a minimum cycle time: check, then apply
    function automatic void timed_set(input logic [2:0] bit_idx,
                                      input logic [1:0] tg_idx,
                                      input logic has_run,
                                      input logic [1:0] rn_idx,
                                      input logic [31:0] min_cycle,
                                      input logic on,
                                      input logic [TIME_BITS-1:0] now,
                                      inout logic [5:0] flags,
                                      inout logic [3:0][TIME_BITS-1:0] tog,
                                      inout logic [2:0][TIME_BITS-1:0] run,
                                      output logic acc,
                                      output logic [1:0] rsn);
        acc = 1'b0;
        rsn = RSN_NONE;
        if (too_soon(now, tog[tg_idx], min_cycle))
        begin
            rsn = RSN_CYCLE;
        end
        else
        begin
            flags[bit_idx] = on;
            tog[tg_idx]    = now;
            if (on && has_run)
            begin
                run[rn_idx] = '0;
            end
            acc = 1'b1;
        end
    endfunction

    // One set request, interlock first
    function automatic void set_act(input logic [2:0] act,
                                    input logic on,
                                    input logic [TIME_BITS-1:0] now,
                                    inout logic [5:0] flags,
                                    inout logic il,
                                    inout logic [3:0][TIME_BITS-1:0] tog,
                                    inout logic [2:0][TIME_BITS-1:0] run,
                                    output logic acc,
                                    output logic [1:0] rsn);
        acc = 1'b0;
        rsn = RSN_NONE;
        unique case (act) inside
            ACT_HEATER1, ACT_HEATER2:
            begin
                il = 1'b0;
                if (on && flags[ACT_EXHAUST])
                begin
                    il  = 1'b1;
                    rsn = RSN_HTR_BLOCKED;
                end
                else if (act == ACT_HEATER1)
                begin
                    timed_set(ACT_HEATER1, TG_H1, 1'b1, RN_H1, cfg.heater_min_cycle_ms,
                              on, now, flags, tog, run, acc, rsn);
                end
                else
                begin
                    timed_set(ACT_HEATER2, TG_H2, 1'b1, RN_H2, cfg.heater_min_cycle_ms,
                              on, now, flags, tog, run, acc, rsn);
                end
            end
            ACT_EXHAUST:
            begin
                il = 1'b0;
                if (on && (flags[ACT_HEATER1] || flags[ACT_HEATER2]))
                begin
                    il  = 1'b1;
                    rsn = RSN_EXH_BLOCKED;
                end
                else
                begin
                    timed_set(ACT_EXHAUST, TG_EX, 1'b0, RN_H1, cfg.exhaust_min_cycle_ms,
                              on, now, flags, tog, run, acc, rsn);
                end
            end
            ACT_CIRC:
            begin
                il              = 1'b0;
                flags[ACT_CIRC] = on;
                acc             = 1'b1;
            end
            ACT_PUMP:
            begin
                il = 1'b0;
                timed_set(ACT_PUMP, TG_PU, 1'b1, RN_PU, cfg.pump_min_cycle_ms,
                          on, now, flags, tog, run, acc, rsn);
            end
            ACT_LIGHT:
            begin
                flags[ACT_LIGHT] = on;
                acc              = 1'b1;
            end
            default:
            begin
            end
        endcase
    endfunction

    assign now_wide = 64'(item.now_ms);
    assign now_t    = now_wide[TIME_BITS-1:0];

    // Decode the request and work out the new state
    always_comb
    begin
        logic [5:0]                flags;
        logic                      il;
        logic                      mode;
        logic [2:0]                last;
        logic [3:0][TIME_BITS-1:0] tog;
        logic [2:0][TIME_BITS-1:0] run;
        logic                      acc;
        logic [1:0]                rsn;
        logic [4:0]                forced;
        logic [1:0]                tone;
        logic                      w_acc;
        logic [1:0]                w_rsn;

        flags  = ctl_cur.on_flags;
        il     = ctl_cur.interlock_seen;
        mode   = ctl_cur.emergency_mode;
        last   = ctl_cur.last_emergency;
        tog    = tog_cur;
        run    = run_cur;
        acc    = 1'b0;
        rsn    = RSN_NONE;
        forced = '0;
        tone   = TONE_NONE;
        w_acc  = 1'b0;
        w_rsn  = RSN_NONE;

        unique case (item.req_type)
            REQ_TICK:
            begin
                // drop over-limit relays, then refresh on-times
                if (flags[ACT_HEATER1] && 64'(run[RN_H1]) > 64'(cfg.heater_max_runtime_ms))
                begin
                    flags[ACT_HEATER1]  = 1'b0;
                    forced[ACT_HEATER1] = 1'b1;
                end
                if (flags[ACT_HEATER2] && 64'(run[RN_H2]) > 64'(cfg.heater_max_runtime_ms))
                begin
                    flags[ACT_HEATER2]  = 1'b0;
                    forced[ACT_HEATER2] = 1'b1;
                end
                if (flags[ACT_PUMP] && 64'(run[RN_PU]) > 64'(cfg.pump_max_runtime_ms))
                begin
                    flags[ACT_PUMP]  = 1'b0;
                    forced[ACT_PUMP] = 1'b1;
                end
                if (flags[ACT_HEATER1])
                begin
                    run[RN_H1] = now_t - tog[TG_H1];
                end
                if (flags[ACT_HEATER2])
                begin
                    run[RN_H2] = now_t - tog[TG_H2];
                end
                if (flags[ACT_PUMP])
                begin
                    run[RN_PU] = now_t - tog[TG_PU];
                end
            end
            REQ_SET:
            begin
                set_act(item.actuator, item.turn_on, now_t, flags, il, tog, run, acc, rsn);
            end
            REQ_EMERG:
            begin
                mode = 1'b1;
                last = item.event_code;
                tone = TONE_BEEP;
                unique case (item.event_code) inside
                    EMG_LOW_TEMP, EMG_FROST:
                    begin
                        flags      = (flags & ~M_EX) | M_H1 | M_H2 | M_CI;
                        tog[TG_H1] = now_t;
                        tog[TG_H2] = now_t;
                    end
                    EMG_HIGH_TEMP:
                    begin
                        flags      = (flags & ~(M_H1 | M_H2 | M_LI)) | M_EX | M_CI;
                        tog[TG_EX] = now_t;
                    end
                    EMG_SECURITY:
                    begin
                        tone = TONE_BURST;
                    end
                    EMG_LEAK:
                    begin
                        flags = flags & ~M_PU;
                    end
                    EMG_POWER:
                    begin
                        flags = flags & ~(M_LI | M_PU);
                    end
                    EMG_HIGH_CO2:
                    begin
                        flags      = (flags & ~(M_H1 | M_H2)) | M_EX | M_CI;
                        tog[TG_EX] = now_t;
                    end
                    default:
                    begin
                        // sensor failure: stop everything, keep circulation
                        flags = M_CI;
                        mode  = 1'b0;
                    end
                endcase
            end
            REQ_WARN:
            begin
                unique case (item.event_code) inside
                    WRN_TEMP_LOW:
                    begin
                        if (!flags[ACT_HEATER1])
                        begin
                            set_act(ACT_HEATER1, 1'b1, now_t, flags, il, tog, run, w_acc, w_rsn);
                        end
                    end
                    WRN_TEMP_HIGH:
                    begin
                        if (!flags[ACT_CIRC])
                        begin
                            set_act(ACT_CIRC, 1'b1, now_t, flags, il, tog, run, w_acc, w_rsn);
                        end
                        if ((flags & (M_EX | M_H1 | M_H2)) == '0)
                        begin
                            set_act(ACT_EXHAUST, 1'b1, now_t, flags, il, tog, run, w_acc, w_rsn);
                        end
                    end
                    WRN_HUM_HIGH, WRN_CO2_HIGH:
                    begin
                        if (!flags[ACT_EXHAUST])
                        begin
                            set_act(ACT_EXHAUST, 1'b1, now_t, flags, il, tog, run, w_acc, w_rsn);
                        end
                    end
                    WRN_CO2_LOW:
                    begin
                        if (flags[ACT_EXHAUST])
                        begin
                            set_act(ACT_EXHAUST, 1'b0, now_t, flags, il, tog, run, w_acc, w_rsn);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            REQ_STOP:
            begin
                flags = '0;
                mode  = 1'b0;
            end
            default:
            begin
            end
        endcase

        ctl_next.on_flags       = flags;
        ctl_next.emergency_mode = mode;
        ctl_next.last_emergency = last;
        ctl_next.interlock_seen = il;
        tog_next                = tog;
        run_next                = run;

        res.accepted         = acc;
        res.block_reason     = rsn;
        res.actuator_on      = flags;
        res.relay_levels     = cfg.relay_polarity_low ? ~flags : flags;
        res.any_on           = (flags != '0);
        res.forced_off       = forced;
        res.emergency_active = mode;
        res.emergency_kind   = last;
        res.interlock_flag   = il;
        res.alarm_tone       = tone;
    end

endmodule

// ----- sv/actuator_safety_interlock_controller_core.sv -----
// Top level of the actuator safety interlock controller: handshakes, state and registers.
// Depends on saic_pkg and saic_eval.
//
// Usage:
//  Requests enter on in_valid / in_stall with req_type, actuator, turn_on,
//  event_code and now_ms; a request is taken on an edge with in_valid high
//  and in_stall low. Every request gives exactly one result on out_valid /
//  out_stall, taken on an edge with out_valid high and out_stall low.
//  The request is held in an input register, then the decode and relay
//  logic fills the result register and updates the state. Throughput is
//  one request per cycle while the receiver does not stall; the state update
//  is a single pass of compares and subtractions between those two registers.
//  When the receiver stalls, the result register holds and the input register
//  keeps one more request, after which in_stall rises until the result goes.
//  Configuration writes use cfg_valid / cfg_ready with cfg_index and cfg_data;
//  cfg_ready is always high and indexes past the register list are dropped.
//  Write configuration only while no request is in flight.
//  Reset clears all relays, toggle and run times and emergency state, and
//  loads the default configuration; no clearing pass is needed.
module actuator_safety_interlock_controller_core #(
    parameter int TIME_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  req_type,
    input  logic [2:0]  actuator,
    input  logic        turn_on,
    input  logic [2:0]  event_code,
    input  logic [31:0] now_ms,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        accepted,
    output logic [1:0]  block_reason,
    output logic [5:0]  actuator_on,
    output logic [5:0]  relay_levels,
    output logic        any_on,
    output logic [4:0]  forced_off,
    output logic        emergency_active,
    output logic [2:0]  emergency_kind,
    output logic        interlock_flag,
    output logic [1:0]  alarm_tone,
    // configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import saic_pkg::*;

    logic                      s1_valid_reg;
    item_t                     item_reg;
    logic                      out_valid_reg;
    res_t                      res_reg;
    cfg_t                      cfg_reg;
    ctl_t                      ctl_reg;
    logic [3:0][TIME_BITS-1:0] tog_reg;
    logic [2:0][TIME_BITS-1:0] run_reg;

    ctl_t                      ctl_next;
    logic [3:0][TIME_BITS-1:0] tog_next;
    logic [2:0][TIME_BITS-1:0] run_next;
    res_t                      res_next;

    logic                      in_take;
    logic                      s1_go;

    // Handshake control
    assign s1_go     = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_go;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    saic_eval #(
        .TIME_BITS (TIME_BITS)
    ) u_eval (
        .cfg      (cfg_reg),
        .item     (item_reg),
        .ctl_cur  (ctl_reg),
        .tog_cur  (tog_reg),
        .run_cur  (run_reg),
        .ctl_next (ctl_next),
        .tog_next (tog_next),
        .run_next (run_next),
        .res      (res_next)
    );

    // Valid flags of both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= in_take || (s1_valid_reg && !s1_go);
            out_valid_reg <= s1_go || (out_valid_reg && out_stall);
        end
    end

    // Hold the request and the result payloads
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.req_type   <= req_type;
            item_reg.actuator   <= actuator;
            item_reg.turn_on    <= turn_on;
            item_reg.event_code <= event_code;
            item_reg.now_ms     <= now_ms;
        end
        if (s1_go)
        begin
            res_reg <= res_next;
        end
    end

    // Advance relay state as each request moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
            tog_reg <= '0;
            run_reg <= '0;
        end
        else if (s1_go)
        begin
            ctl_reg <= ctl_next;
            tog_reg <= tog_next;
            run_reg <= run_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.heater_min_cycle_ms   <= RST_HTR_MIN;
            cfg_reg.exhaust_min_cycle_ms  <= RST_EXH_MIN;
            cfg_reg.pump_min_cycle_ms     <= RST_PUMP_MIN;
            cfg_reg.heater_max_runtime_ms <= RST_HTR_MAX;
            cfg_reg.pump_max_runtime_ms   <= RST_PUMP_MAX;
            cfg_reg.relay_polarity_low    <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_HTR_MIN:  cfg_reg.heater_min_cycle_ms   <= cfg_data;
                CFG_EXH_MIN:  cfg_reg.exhaust_min_cycle_ms  <= cfg_data;
                CFG_PUMP_MIN: cfg_reg.pump_min_cycle_ms     <= cfg_data;
                CFG_HTR_MAX:  cfg_reg.heater_max_runtime_ms <= cfg_data;
                CFG_PUMP_MAX: cfg_reg.pump_max_runtime_ms   <= cfg_data;
                CFG_POLARITY: cfg_reg.relay_polarity_low    <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Drive the result ports
    assign out_valid        = out_valid_reg;
    assign accepted         = res_reg.accepted;
    assign block_reason     = res_reg.block_reason;
    assign actuator_on      = res_reg.actuator_on;
    assign relay_levels     = res_reg.relay_levels;
    assign any_on           = res_reg.any_on;
    assign forced_off       = res_reg.forced_off;
    assign emergency_active = res_reg.emergency_active;
    assign emergency_kind   = res_reg.emergency_kind;
    assign interlock_flag   = res_reg.interlock_flag;
    assign alarm_tone       = res_reg.alarm_tone;

    // An applied request never carries a block reason
    a_accept_no_reason: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.accepted |-> res_reg.block_reason == RSN_NONE)
        else $error("applied request reported a block reason");

    // Runtime limits only drop heaters and the pump
    a_forced_bits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg.forced_off & FORCED_NEVER) == '0)
        else $error("forced_off names a relay without a runtime limit");

    // A request leaving the input register shows up as a result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go |=> out_valid_reg)
        else $error("request advanced but no result appeared");

    // The any_on flag tracks the logical relay mask
    a_any_on: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> res_reg.any_on == (res_reg.actuator_on != '0))
        else $error("any_on disagrees with actuator_on");

endmodule
